>>> rtl/core/interval_set_breakpoint_table_defines.svh
// assertion macros for the interval set breakpoint table
// used by the top level; no other dependencies
`ifndef INTERVAL_SET_BREAKPOINT_TABLE_DEFINES_SVH
`define INTERVAL_SET_BREAKPOINT_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define ISBT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("isbt check failed");
`define ISBT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("isbt check failed");
`else
`define ISBT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ISBT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/isbt_pkg.sv
// shared types for the interval set breakpoint table
// payload structs, op codes, controller states and command/status groups
package isbt_pkg;

   // member width, fixed by the payload structs below
   localparam int MEMBER_BITS = 32;

   typedef enum logic [1:0] {
      OP_FILL  = 2'd0,
      OP_EMPTY = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] range_begin;
      logic [31:0] range_end;
   } req_type;

   typedef struct packed {
      logic        begin_is_member;
      logic [32:0] members_in_range;
      logic        range_empty;
      logic        range_full;
      logic        set_empty;
      logic [31:0] lowest_member;
      logic [31:0] highest_member;
      logic        overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UPD_RD,
      ST_UPD_EV,
      ST_UPD_TAIL,
      ST_QRY_RD,
      ST_QRY_EV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic upd_init;
      logic rd;
      logic upd_step;
      logic tail;
      logic commit;
      logic clear;
      logic qry_init;
      logic qry_step;
      logic qry_fin;
   } cmd_type;

   typedef struct packed {
      logic do_update;
      logic do_clear;
      logic at_end;
      logic upd_done;
      logic second;
   } status_type;

endpackage

>>> rtl/core/isbt_ram.sv
// generic single write port ram with registered read
// no package dependencies
module isbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> rtl/core/isbt_ctrl.sv
// controller for the interval set breakpoint table
// sequences merge and query passes; uses isbt_pkg
module isbt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  isbt_pkg::status_type status,
   output isbt_pkg::cmd_type    cmd
);
   import isbt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.do_update) begin
               cmd.upd_init = 1'b1;
               state_in     = ST_UPD_RD;
            end else begin
               cmd.clear    = status.do_clear;
               cmd.qry_init = 1'b1;
               state_in     = ST_QRY_RD;
            end
         end
         ST_UPD_RD: begin
            if (status.upd_done) begin
               cmd.commit   = 1'b1;
               cmd.qry_init = 1'b1;
               state_in     = ST_QRY_RD;
            end else begin
               // past the last entry the eval step still runs to close the range
               cmd.rd   = !status.at_end;
               state_in = ST_UPD_EV;
            end
         end
         ST_UPD_EV: begin
            cmd.upd_step = 1'b1;
            state_in     = status.second ? ST_UPD_TAIL : ST_UPD_RD;
         end
         ST_UPD_TAIL: begin
            cmd.tail = 1'b1;
            state_in = ST_UPD_RD;
         end
         ST_QRY_RD: begin
            if (status.at_end) begin
               cmd.qry_fin = 1'b1;
               state_in    = ST_RESP;
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_QRY_EV;
            end
         end
         ST_QRY_EV: begin
            cmd.qry_step = 1'b1;
            state_in     = ST_QRY_RD;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/isbt_dp.sv
// datapath for the interval set breakpoint table: two ping-pong breakpoint
// banks, merge writer, query accumulator and result register; uses isbt_pkg, isbt_ram
module isbt_dp #(
   parameter int MAX_BREAKPOINTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  isbt_pkg::req_type    req_data,
   input  isbt_pkg::cmd_type    cmd,
   output isbt_pkg::status_type status,
   output isbt_pkg::rsp_type    rsp_data
);
   import isbt_pkg::*;

   localparam int KW = MEMBER_BITS + 1;
   localparam int EW = KW + 1;
   localparam int AW = $clog2(MAX_BREAKPOINTS);
   localparam int CW = $clog2(MAX_BREAKPOINTS + 3);
   localparam logic [CW-1:0] DEPTH_C = CW'(MAX_BREAKPOINTS);

   typedef enum logic [1:0] {
      PH_BELOW,
      PH_INSIDE,
      PH_ABOVE
   } phase_type;

   // request
   op_type          op_ff, op_in;
   logic [KW-1:0]   b_ff, b_in;
   logic [KW-1:0]   e1_ff, e1_in;
   // table control
   logic            sel_ff, sel_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   wptr_ff, wptr_in;
   phase_type       phase_ff, phase_in;
   logic            ovf_ff, ovf_in;
   // query accumulation
   logic            seen_ff, seen_in;
   logic            bim_ff, bim_in;
   logic            remp_ff, remp_in;
   logic            rful_ff, rful_in;
   logic [KW-1:0]   prev_ff, prev_in;
   logic [KW-1:0]   low_ff, low_in;
   logic [KW-1:0]   high_ff, high_in;
   logic [KW-1:0]   acc_ff, acc_in;
   rsp_type         rsp_ff, rsp_in;

   logic [EW-1:0]   rd0, rd1, ent;
   logic [KW-1:0]   k;
   logic            f, v, at_end;
   logic            wr_en_e, adv, second;
   logic [EW-1:0]   wr_word_e, wr_word;
   logic            wr_go, wr_ok;
   phase_type       phase_nx;
   logic            first, hit, add;
   logic [KW-1:0]   lo, hi;
   logic            old1, empty_set;

   assign ent    = sel_ff ? rd1 : rd0;
   assign k      = ent[KW-1:0];
   assign f      = ent[KW];
   assign v      = (op_ff == OP_FILL);
   assign at_end = (idx_ff >= cnt_ff);

   assign status.do_update = ((op_ff == OP_FILL) || (op_ff == OP_EMPTY)) && (b_ff < e1_ff);
   assign status.do_clear  = (op_ff == OP_CLEAR);
   assign status.at_end    = at_end;
   assign status.upd_done  = at_end && (phase_ff == PH_ABOVE);
   assign status.second    = second;

   // merge decision for the entry at idx_ff (or the end of the table)
   always_comb begin
      wr_en_e   = 1'b0;
      wr_word_e = ent;
      adv       = 1'b0;
      second    = 1'b0;
      phase_nx  = phase_ff;
      old1      = !at_end && f;
      case (phase_ff)
         PH_BELOW: begin
            if (!at_end && (k < b_ff)) begin
               wr_en_e = 1'b1;
               adv     = 1'b1;
            end else if (!at_end && (k == b_ff)) begin
               wr_en_e  = (f != v);
               adv      = 1'b1;
               phase_nx = PH_INSIDE;
            end else begin
               // split the run at begin, keeping its old mark below
               wr_en_e   = (old1 != v);
               wr_word_e = {old1, b_ff};
               phase_nx  = PH_INSIDE;
            end
         end
         PH_INSIDE: begin
            if (!at_end && (k < e1_ff)) begin
               adv = 1'b1;
            end else if (!at_end && (k == e1_ff)) begin
               wr_en_e  = (f == v);
               adv      = 1'b1;
               phase_nx = PH_ABOVE;
            end else if (at_end) begin
               wr_en_e   = v;
               wr_word_e = {v, e1_ff};
               phase_nx  = PH_ABOVE;
            end else if (f != v) begin
               // close the range, then copy this entry on the next cycle
               wr_en_e   = 1'b1;
               wr_word_e = {v, e1_ff};
               second    = 1'b1;
               adv       = 1'b1;
               phase_nx  = PH_ABOVE;
            end else begin
               wr_en_e  = 1'b1;
               adv      = 1'b1;
               phase_nx = PH_ABOVE;
            end
         end
         PH_ABOVE: begin
            wr_en_e = !at_end;
            adv     = !at_end;
         end
         default: begin
            phase_nx = PH_ABOVE;
         end
      endcase
   end

   assign wr_go   = (cmd.upd_step && wr_en_e) || cmd.tail;
   assign wr_word = cmd.tail ? ent : wr_word_e;
   assign wr_ok   = wr_go && (wptr_ff < DEPTH_C);

   // query accumulation terms
   assign first     = !seen_ff && (k > b_ff);
   assign hit       = seen_ff || first;
   assign lo        = first ? b_ff : prev_ff;
   assign hi        = (k < e1_ff) ? k : e1_ff;
   assign add       = hit && f && (lo < e1_ff);
   assign empty_set = (cnt_ff == '0);

   always_comb begin
      op_in    = op_ff;
      b_in     = b_ff;
      e1_in    = e1_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      wptr_in  = wptr_ff;
      phase_in = phase_ff;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      bim_in   = bim_ff;
      remp_in  = remp_ff;
      rful_in  = rful_ff;
      prev_in  = prev_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      acc_in   = acc_ff;
      rsp_in   = rsp_ff;

      if (cmd.load) begin
         op_in  = req_data.op;
         b_in   = {1'b0, MEMBER_BITS'(req_data.range_begin)};
         e1_in  = {1'b0, MEMBER_BITS'(req_data.range_end)} + KW'(1);
         ovf_in = 1'b0;
      end
      if (cmd.upd_init) begin
         idx_in   = '0;
         wptr_in  = '0;
         phase_in = PH_BELOW;
      end
      if (cmd.upd_step) begin
         phase_in = phase_nx;
         if (adv) begin
            idx_in = idx_ff + CW'(1);
         end
      end
      if (wr_go) begin
         wptr_in = wptr_ff + CW'(1);
      end
      if (cmd.commit) begin
         if (wptr_ff > DEPTH_C) begin
            ovf_in = 1'b1;
         end else begin
            sel_in = !sel_ff;
            cnt_in = wptr_ff;
         end
      end
      if (cmd.clear) begin
         cnt_in = '0;
      end
      if (cmd.qry_init) begin
         idx_in  = '0;
         seen_in = 1'b0;
         acc_in  = '0;
      end
      if (cmd.qry_step) begin
         idx_in  = idx_ff + CW'(1);
         prev_in = k;
         high_in = k - KW'(1);
         if (idx_ff == '0) begin
            low_in = k;
         end
         if (first) begin
            seen_in = 1'b1;
            bim_in  = f;
            remp_in = !f && (k >= e1_ff);
            rful_in = f && (k >= e1_ff);
         end
         if (add) begin
            acc_in = acc_ff + (hi - lo);
         end
      end
      if (cmd.qry_fin) begin
         rsp_in.begin_is_member  = seen_ff && bim_ff;
         rsp_in.members_in_range = 33'(acc_ff);
         rsp_in.range_empty      = !seen_ff || remp_ff;
         rsp_in.range_full       = seen_ff && rful_ff;
         rsp_in.set_empty        = empty_set;
         rsp_in.lowest_member    = empty_set ? 32'd0 : 32'(low_ff[MEMBER_BITS-1:0]);
         rsp_in.highest_member   = empty_set ? 32'd0 : 32'(high_ff[MEMBER_BITS-1:0]);
         rsp_in.overflow         = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         sel_ff <= sel_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      b_ff     <= b_in;
      e1_ff    <= e1_in;
      idx_ff   <= idx_in;
      wptr_ff  <= wptr_in;
      phase_ff <= phase_in;
      ovf_ff   <= ovf_in;
      seen_ff  <= seen_in;
      bim_ff   <= bim_in;
      remp_ff  <= remp_in;
      rful_ff  <= rful_in;
      prev_ff  <= prev_in;
      low_ff   <= low_in;
      high_ff  <= high_in;
      acc_ff   <= acc_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // the live table sits in bank sel_ff; the merge pass writes the other one
   isbt_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_BREAKPOINTS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_ok && sel_ff),
      .wr_addr (wptr_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd0)
   );

   isbt_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_BREAKPOINTS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_ok && !sel_ff),
      .wr_addr (wptr_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd1)
   );

endmodule

>>> rtl/core/interval_set_breakpoint_table.sv
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  isbt_pkg::req_type
// rsp      out  rsp_valid / rsp_stall  isbt_pkg::rsp_type
//
// an update runs a merge pass over the stored breakpoints into the other bank, then
// every request runs a query pass over the table, with accept, dispatch and result
// states around them; each pass reads one breakpoint at a time through the single
// read port of the breakpoint ram
// synchronous reset empties the table at once, no clearing pass
// req_stall stays high from an accepted transfer until its result transfer completes
// top level of the interval set breakpoint table; uses isbt_pkg, isbt_ctrl, isbt_dp
`include "interval_set_breakpoint_table_defines.svh"

module interval_set_breakpoint_table #(
   parameter int MAX_BREAKPOINTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  isbt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output isbt_pkg::rsp_type rsp_data
);
   import isbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   isbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   isbt_dp #(
      .MAX_BREAKPOINTS (MAX_BREAKPOINTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   `ISBT_ASSERT_NXT(a_no_early_rsp, clock, reset, req_valid && !req_stall, !rsp_valid)
   `ISBT_ASSERT_IMP(a_range_excl, clock, reset, rsp_valid, !(rsp_data.range_empty && rsp_data.range_full))
   `ISBT_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && rsp_data.set_empty, rsp_data.lowest_member == 32'd0 && rsp_data.highest_member == 32'd0 && !rsp_data.begin_is_member && rsp_data.members_in_range == 33'd0)
   `ISBT_ASSERT_IMP(a_ovf_full, clock, reset, rsp_valid && rsp_data.overflow, !rsp_data.set_empty)

endmodule
